// File: rtl/core/salc_pkg.sv
package salc_pkg;

    // Fixed field widths of the item and the configuration port.
    localparam int ADDR_W      = 64;
    localparam int OP_W        = 2;
    localparam int OUTCOME_W   = 2;
    localparam int CNT_W       = 32;
    localparam int TAG_W       = 62;
    localparam int AGE_W       = 3;
    localparam int SET_BITS_W  = 4;
    localparam int WAYS_W      = 4;
    localparam int OFFSET_W    = 5;
    localparam int SB_W        = 5;
    localparam int SHIFT_W     = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int MAX_OFFSET  = 16;

    // Default geometry.
    localparam int DEF_MAX_SET_BITS = 10;
    localparam int DEF_MAX_WAYS     = 8;

    // Ages saturate at this rank.
    localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;

    // Register reset values.
    localparam logic [SET_BITS_W-1:0] SET_BITS_RST = 4'd4;
    localparam logic [WAYS_W-1:0]     WAYS_RST     = 4'd1;
    localparam logic [OFFSET_W-1:0]   OFFSET_RST   = 5'd4;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_STORE   = 2'd1;
    localparam logic [OP_W-1:0] OP_MODIFY  = 2'd2;
    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

    // Outcome codes.
    localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_MISS  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_WRITE,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_en;
        logic accept;
        logic read_en;
        logic cmp_en;
        logic write_en;
        logic second;
        logic load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic in_lookup;
        logic is_modify;
        logic out_free;
    } ctrl_sts_t;

endpackage

// File: rtl/core/salc_ctrl.sv
module salc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  salc_pkg::ctrl_sts_t  sts,
    output salc_pkg::ctrl_cmd_t  cmd,
    input  logic                 in_valid,
    output logic                 in_stall
);
    import salc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   second_reg;
    logic   second_next;

    // State and pass registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        cmd         = '0;
        cmd.second  = second_reg;
        in_stall    = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept  = 1'b1;
                    second_next = 1'b0;
                    state_next  = sts.in_lookup ? ST_READ : ST_FINISH;
                end
            end
            ST_READ:
            begin
                cmd.read_en = 1'b1;
                state_next  = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.cmp_en = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.write_en = 1'b1;
                if (sts.is_modify && !second_reg)
                begin
                    second_next = 1'b1;
                    state_next  = ST_READ;
                end
                else if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // A result is only loaded into a free output register.
    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded while output register busy");

    // A second lookup is only ever done for a modify.
    a_second_only_modify: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.write_en && cmd.second) |-> sts.is_modify)
        else $error("second lookup for an item that is not a modify");
`endif

endmodule

// File: rtl/core/salc_dp.sv
module salc_dp #(
    parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  salc_pkg::ctrl_cmd_t                cmd,
    output salc_pkg::ctrl_sts_t                sts,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [salc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [salc_pkg::OP_W-1:0]          operation,
    input  logic [salc_pkg::ADDR_W-1:0]        address,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [salc_pkg::OUTCOME_W-1:0]     outcome,
    output logic                               extra_hit,
    output logic [salc_pkg::CNT_W-1:0]         hit_total,
    output logic [salc_pkg::CNT_W-1:0]         miss_total,
    output logic [salc_pkg::CNT_W-1:0]         eviction_total
);
    import salc_pkg::*;

    localparam int SETS  = 1 << MAX_SET_BITS;
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    // Configuration registers.
    logic [SET_BITS_W-1:0] set_bits_reg;
    logic [WAYS_W-1:0]     ways_reg;
    logic [OFFSET_W-1:0]   offset_reg;

    // Address decode.
    logic [SB_W-1:0]         sb_w;
    logic [OFFSET_W-1:0]     ob_w;
    logic [SHIFT_W-1:0]      sh_w;
    logic [ADDR_W-1:0]       block_w;
    logic [MAX_SET_BITS-1:0] set_mask_w;
    logic [MAX_SET_BITS-1:0] set_w;
    logic [TAG_W-1:0]        tag_w;

    // Item registers.
    logic [MAX_SET_BITS-1:0] set_reg;
    logic [TAG_W-1:0]        tag_reg;
    logic                    modify_reg;
    logic [MAX_SET_BITS-1:0] clr_idx_reg;

    // Tag store, one row per set.
    logic [MAX_WAYS-1:0]                 valid_mem [SETS];
    logic [MAX_WAYS-1:0][TAG_W-1:0]      tag_mem   [SETS];
    logic [MAX_WAYS-1:0][AGE_W-1:0]      age_mem   [SETS];
    logic [MAX_WAYS-1:0]                 valid_rd_reg;
    logic [MAX_WAYS-1:0][TAG_W-1:0]      tag_rd_reg;
    logic [MAX_WAYS-1:0][AGE_W-1:0]      age_rd_reg;

    // Compare stage.
    logic [MAX_WAYS-1:0] use_mask;
    logic [MAX_WAYS-1:0] match_w;
    logic                hit_any_w;
    logic [WAY_W-1:0]    hit_way_w;
    logic                free_any_w;
    logic [WAY_W-1:0]    free_way_w;
    logic [AGE_W-1:0]    best_age_w;
    logic [WAY_W-1:0]    max_way_w;
    logic                hit_reg;
    logic [WAY_W-1:0]    hit_way_reg;
    logic [AGE_W-1:0]    hit_age_reg;
    logic [WAY_W-1:0]    victim_reg;
    logic                evict_reg;

    // Update stage.
    logic [MAX_WAYS-1:0]            valid_new;
    logic [MAX_WAYS-1:0][TAG_W-1:0] tag_new;
    logic [MAX_WAYS-1:0][AGE_W-1:0] age_new;

    // Totals and result.
    logic [CNT_W-1:0]     hit_cnt_reg;
    logic [CNT_W-1:0]     hit_cnt_next;
    logic [CNT_W-1:0]     miss_cnt_reg;
    logic [CNT_W-1:0]     miss_cnt_next;
    logic [CNT_W-1:0]     evict_cnt_reg;
    logic [CNT_W-1:0]     evict_cnt_next;
    logic [OUTCOME_W-1:0] outcome_reg;
    logic [OUTCOME_W-1:0] outcome_next;
    logic                 extra_reg;
    logic                 extra_next;

    // Output register.
    logic                 out_valid_reg;
    logic [OUTCOME_W-1:0] outcome_out_reg;
    logic                 extra_out_reg;
    logic [CNT_W-1:0]     hit_out_reg;
    logic [CNT_W-1:0]     miss_out_reg;
    logic [CNT_W-1:0]     evict_out_reg;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg <= SET_BITS_RST;
            ways_reg     <= WAYS_RST;
            offset_reg   <= OFFSET_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SET_BITS:    set_bits_reg <= cfg_data[SET_BITS_W-1:0];
                CFG_WAYS_IN_USE: ways_reg     <= cfg_data[WAYS_W-1:0];
                CFG_OFFSET_BITS: offset_reg   <= cfg_data[OFFSET_W-1:0];
                default:         ;
            endcase
        end
    end

    // Clamp the geometry and split the address into set and tag.
    always_comb
    begin
        if (set_bits_reg == '0)
        begin
            sb_w = SB_W'(1);
        end
        else if (int'(set_bits_reg) > MAX_SET_BITS)
        begin
            sb_w = SB_W'(MAX_SET_BITS);
        end
        else
        begin
            sb_w = SB_W'(set_bits_reg);
        end
        if (offset_reg == '0)
        begin
            ob_w = OFFSET_W'(1);
        end
        else if (int'(offset_reg) > MAX_OFFSET)
        begin
            ob_w = OFFSET_W'(MAX_OFFSET);
        end
        else
        begin
            ob_w = offset_reg;
        end
        sh_w    = SHIFT_W'(sb_w) + SHIFT_W'(ob_w);
        block_w = address >> ob_w;
        for (int i = 0; i < MAX_SET_BITS; i++)
        begin
            set_mask_w[i] = (i < int'(sb_w));
        end
        set_w = block_w[MAX_SET_BITS-1:0] & set_mask_w;
        tag_w = TAG_W'(address >> sh_w);
    end

    // Capture the decoded item.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            set_reg    <= set_w;
            tag_reg    <= tag_w;
            modify_reg <= (operation == OP_MODIFY);
        end
    end

    // Row pointer of the clearing pass after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
        end
        else if (cmd.clear_en)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    // Tag store: one write and one registered read a cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.clear_en)
        begin
            valid_mem[clr_idx_reg] <= '0;
            age_mem[clr_idx_reg]   <= '0;
        end
        else if (cmd.write_en)
        begin
            valid_mem[set_reg] <= valid_new;
            tag_mem[set_reg]   <= tag_new;
            age_mem[set_reg]   <= age_new;
        end
        if (cmd.read_en)
        begin
            valid_rd_reg <= valid_mem[set_reg];
            tag_rd_reg   <= tag_mem[set_reg];
            age_rd_reg   <= age_mem[set_reg];
        end
    end

    // Ways in use; way zero always takes part.
    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            use_mask[w] = (w == 0) || (w < int'(ways_reg));
        end
    end

    // Compare all ways, then find the first hit, first free way and oldest way.
    always_comb
    begin
        hit_any_w  = 1'b0;
        hit_way_w  = '0;
        free_any_w = 1'b0;
        free_way_w = '0;
        best_age_w = '0;
        max_way_w  = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            match_w[w] = use_mask[w] && valid_rd_reg[w] && (tag_rd_reg[w] == tag_reg);
        end
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (match_w[w] && !hit_any_w)
            begin
                hit_any_w = 1'b1;
                hit_way_w = WAY_W'(w);
            end
            if (use_mask[w] && !valid_rd_reg[w] && !free_any_w)
            begin
                free_any_w = 1'b1;
                free_way_w = WAY_W'(w);
            end
            if (use_mask[w] && (age_rd_reg[w] > best_age_w))
            begin
                best_age_w = age_rd_reg[w];
                max_way_w  = WAY_W'(w);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cmp_en)
        begin
            hit_reg     <= hit_any_w;
            hit_way_reg <= hit_way_w;
            hit_age_reg <= age_rd_reg[hit_way_w];
            victim_reg  <= free_any_w ? free_way_w : max_way_w;
            evict_reg   <= !free_any_w;
        end
    end

    // New row: refresh the hit line or fill the victim, and age the others.
    always_comb
    begin
        valid_new = valid_rd_reg;
        tag_new   = tag_rd_reg;
        age_new   = age_rd_reg;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (hit_reg)
            begin
                if (WAY_W'(w) == hit_way_reg)
                begin
                    age_new[w] = '0;
                end
                else if (use_mask[w] && valid_rd_reg[w] && (age_rd_reg[w] < hit_age_reg))
                begin
                    age_new[w] = age_rd_reg[w] + 1'b1;
                end
            end
            else
            begin
                if (WAY_W'(w) == victim_reg)
                begin
                    valid_new[w] = 1'b1;
                    tag_new[w]   = tag_reg;
                    age_new[w]   = '0;
                end
                else if (use_mask[w] && valid_rd_reg[w] && (age_rd_reg[w] != AGE_MAX))
                begin
                    age_new[w] = age_rd_reg[w] + 1'b1;
                end
            end
        end
    end

    // Saturating totals and the outcome of each lookup.
    always_comb
    begin
        hit_cnt_next   = hit_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        evict_cnt_next = evict_cnt_reg;
        outcome_next   = outcome_reg;
        extra_next     = extra_reg;
        if (cmd.accept)
        begin
            outcome_next = OUT_HIT;
            extra_next   = 1'b0;
        end
        else if (cmd.write_en)
        begin
            if (hit_reg)
            begin
                if (hit_cnt_reg != '1)
                begin
                    hit_cnt_next = hit_cnt_reg + 1'b1;
                end
            end
            else
            begin
                if (miss_cnt_reg != '1)
                begin
                    miss_cnt_next = miss_cnt_reg + 1'b1;
                end
                if (evict_reg && (evict_cnt_reg != '1))
                begin
                    evict_cnt_next = evict_cnt_reg + 1'b1;
                end
            end
            if (!cmd.second)
            begin
                if (hit_reg)
                begin
                    outcome_next = OUT_HIT;
                end
                else if (evict_reg)
                begin
                    outcome_next = OUT_EVICT;
                end
                else
                begin
                    outcome_next = OUT_MISS;
                end
            end
            else
            begin
                extra_next = hit_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
        end
        else
        begin
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            evict_cnt_reg <= evict_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        outcome_reg <= outcome_next;
        extra_reg   <= extra_next;
    end

    // Output register: holds the item until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            outcome_out_reg <= outcome_next;
            extra_out_reg   <= extra_next;
            hit_out_reg     <= hit_cnt_next;
            miss_out_reg    <= miss_cnt_next;
            evict_out_reg   <= evict_cnt_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign outcome        = outcome_out_reg;
    assign extra_hit      = extra_out_reg;
    assign hit_total      = hit_out_reg;
    assign miss_total     = miss_out_reg;
    assign eviction_total = evict_out_reg;

    // Status back to the controller.
    assign sts.clr_last  = &clr_idx_reg;
    assign sts.in_lookup = (operation != OP_UNKNOWN);
    assign sts.is_modify = modify_reg;
    assign sts.out_free  = !out_valid_reg || out_stall == 1'b0;

`ifndef SYNTHESIS
    // The clearing pass and a row update never share the write port.
    a_clear_no_update: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_en |-> !cmd.write_en)
        else $error("row update during clearing pass");

    // The hit total only ever steps up by one.
    a_hit_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(hit_cnt_reg) |-> (hit_cnt_reg == $past(hit_cnt_reg) + 1'b1))
        else $error("hit total jumped");

    // The miss total only ever steps up by one.
    a_miss_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(miss_cnt_reg) |-> (miss_cnt_reg == $past(miss_cnt_reg) + 1'b1))
        else $error("miss total jumped");
`endif

endmodule

// File: rtl/core/set_assoc_lru_cache_model_core.sv
// Set-associative cache tag model with LRU replacement.
// Input channel (in_valid / in_stall): one item is an operation (load, store,
// modify) and a 64-bit byte address. Output channel (out_valid / out_stall):
// one item per input, with the outcome of the first lookup, the hit flag of a
// modify's second lookup and the saturating hit, miss and eviction totals.
// Register port (cfg_valid / cfg_ready, cfg_index, cfg_data) sets the set
// bits, ways in use and offset bits; write it only while the block is idle.
// Sequence: a load or store passes the read, compare and write states, a modify
// passes them twice, and an unknown operation makes no lookup; the result is
// then loaded into the output register, from the finish state if it is not yet
// free. The input takes the next item only once that result is loaded. Each
// lookup is a read, compare and write-back of one set row in the tag store;
// the controller takes items one at a time. After reset a clearing pass zeroes
// the valid bits and ages of every row; in_stall stays high until it finishes.
// The output register frees the input side: a new item is accepted while the
// previous result waits. If out_stall holds the result, a finished item waits
// inside the block until the output register is taken.
module set_assoc_lru_cache_model_core #(
    parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [salc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [salc_pkg::OP_W-1:0]          operation,
    input  logic [salc_pkg::ADDR_W-1:0]        address,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [salc_pkg::OUTCOME_W-1:0]     outcome,
    output logic                               extra_hit,
    output logic [salc_pkg::CNT_W-1:0]         hit_total,
    output logic [salc_pkg::CNT_W-1:0]         miss_total,
    output logic [salc_pkg::CNT_W-1:0]         eviction_total
);
    import salc_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // Sequencer.
    salc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .sts      (sts),
        .cmd      (cmd),
        .in_valid (in_valid),
        .in_stall (in_stall)
    );

    // Tag store, replacement logic, totals and output register.
    salc_dp #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .operation      (operation),
        .address        (address),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .outcome        (outcome),
        .extra_hit      (extra_hit),
        .hit_total      (hit_total),
        .miss_total     (miss_total),
        .eviction_total (eviction_total)
    );

endmodule

// File: tb/sv/set_assoc_lru_cache_model_core_tb.sv
module set_assoc_lru_cache_model_core_tb;
    import salc_pkg::*;

    localparam int SETS        = 1 << DEF_MAX_SET_BITS;
    localparam int LINES       = SETS * DEF_MAX_WAYS;
    localparam int IDLE_LIMIT  = 5000;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_LEN    = 400;
    localparam int DRAIN_WAIT  = 20;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 150;
    localparam int REPORT_MAX  = 10;

    // Register index that selects no register.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic                 extra_hit;
        logic [CNT_W-1:0]     hits;
        logic [CNT_W-1:0]     misses;
        logic [CNT_W-1:0]     evictions;
    } access_result_t;

    // Keeps a private copy of the tag store and totals, predicts the result of
    // every accepted item and compares it with what the block returns.
    class cache_scoreboard;
        logic [SET_BITS_W-1:0] set_bits_reg;
        logic [WAYS_W-1:0]     ways_reg;
        logic [OFFSET_W-1:0]   offset_reg;
        bit                    way_valid [LINES];
        logic [TAG_W-1:0]      way_tag [LINES];
        logic [AGE_W-1:0]      way_rank [LINES];
        logic [CNT_W-1:0]      hit_count;
        logic [CNT_W-1:0]      miss_count;
        logic [CNT_W-1:0]      evict_count;
        access_result_t        expected_results [$];
        int                    errors;
        int                    checked;
        int                    seen_hits;
        int                    seen_misses;
        int                    seen_evicts;
        int                    seen_extra;

        function new();
            set_bits_reg = SET_BITS_RST;
            ways_reg     = WAYS_RST;
            offset_reg   = OFFSET_RST;
            foreach (way_valid[i])
            begin
                way_valid[i] = 1'b0;
                way_tag[i]   = '0;
                way_rank[i]  = '0;
            end
            hit_count   = '0;
            miss_count  = '0;
            evict_count = '0;
            errors      = 0;
            checked     = 0;
            seen_hits   = 0;
            seen_misses = 0;
            seen_evicts = 0;
            seen_extra  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SET_BITS:    set_bits_reg = data[SET_BITS_W-1:0];
                CFG_WAYS_IN_USE: ways_reg = data[WAYS_W-1:0];
                CFG_OFFSET_BITS: offset_reg = data[OFFSET_W-1:0];
                default:         ;
            endcase
        endfunction

        // Register values as the block applies them, clamped to their ranges.
        function int eff_set_bits();
            if (set_bits_reg < 1)
                return 1;
            if (set_bits_reg > DEF_MAX_SET_BITS)
                return DEF_MAX_SET_BITS;
            return int'(set_bits_reg);
        endfunction

        function int eff_ways();
            if (ways_reg < 1)
                return 1;
            if (ways_reg > DEF_MAX_WAYS)
                return DEF_MAX_WAYS;
            return int'(ways_reg);
        endfunction

        function int eff_offset_bits();
            if (offset_reg < 1)
                return 1;
            if (offset_reg > MAX_OFFSET)
                return MAX_OFFSET;
            return int'(offset_reg);
        endfunction

        function logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
            return (c == '1) ? c : c + 1'b1;
        endfunction

        // One lookup of the set that the address selects, with LRU update.
        function logic [OUTCOME_W-1:0] access_set(logic [ADDR_W-1:0] addr);
            int                   sbits;
            int                   nways;
            int                   obits;
            int                   base;
            int                   hit_way;
            int                   victim;
            logic [ADDR_W-1:0]    block_addr;
            logic [ADDR_W-1:0]    tag;
            logic [AGE_W-1:0]     rank;
            logic [AGE_W-1:0]     best;
            logic [OUTCOME_W-1:0] result;
            sbits      = eff_set_bits();
            nways      = eff_ways();
            obits      = eff_offset_bits();
            block_addr = addr >> obits;
            tag        = block_addr >> sbits;
            base       = int'(block_addr & ((64'd1 << sbits) - 64'd1)) * DEF_MAX_WAYS;

            hit_way = -1;
            for (int w = 0; w < nways; w++)
            begin
                if (hit_way < 0 && way_valid[base + w] && way_tag[base + w] == tag[TAG_W-1:0])
                    hit_way = w;
            end

            // Hit: lines more recent than the hit line age by one.
            if (hit_way >= 0)
            begin
                rank = way_rank[base + hit_way];
                for (int k = 0; k < nways; k++)
                begin
                    if (k != hit_way && way_valid[base + k] && way_rank[base + k] < rank
                        && way_rank[base + k] != AGE_MAX)
                        way_rank[base + k] = way_rank[base + k] + 1'b1;
                end
                way_rank[base + hit_way] = '0;
                hit_count = sat_inc(hit_count);
                return OUT_HIT;
            end

            // Miss: fill the first free way, else evict the oldest one.
            miss_count = sat_inc(miss_count);
            result     = OUT_MISS;
            victim     = -1;
            for (int w = 0; w < nways; w++)
            begin
                if (victim < 0 && !way_valid[base + w])
                    victim = w;
            end
            if (victim < 0)
            begin
                best   = '0;
                victim = 0;
                for (int w = 0; w < nways; w++)
                begin
                    if (way_rank[base + w] > best)
                    begin
                        best   = way_rank[base + w];
                        victim = w;
                    end
                end
                evict_count = sat_inc(evict_count);
                result      = OUT_EVICT;
            end
            for (int w = 0; w < nways; w++)
            begin
                if (w != victim && way_valid[base + w] && way_rank[base + w] != AGE_MAX)
                    way_rank[base + w] = way_rank[base + w] + 1'b1;
            end
            way_valid[base + victim] = 1'b1;
            way_tag[base + victim]   = tag[TAG_W-1:0];
            way_rank[base + victim]  = '0;
            return result;
        endfunction

        function void note_input(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr);
            access_result_t r;
            // An unknown operation makes no lookup and reports a zero outcome.
            r.outcome   = OUT_HIT;
            r.extra_hit = 1'b0;
            if (op != OP_UNKNOWN)
            begin
                r.outcome = access_set(addr);
                if (op == OP_MODIFY)
                    r.extra_hit = (access_set(addr) == OUT_HIT);
            end
            r.hits      = hit_count;
            r.misses    = miss_count;
            r.evictions = evict_count;
            if (op != OP_UNKNOWN)
            begin
                case (r.outcome)
                    OUT_HIT:  seen_hits++;
                    OUT_MISS: seen_misses++;
                    default:  seen_evicts++;
                endcase
            end
            if (r.extra_hit)
                seen_extra++;
            expected_results.push_back(r);
        endfunction

        function void check_result(access_result_t got);
            access_result_t want;
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("Unexpected result item: outcome %0d extra %0d totals %0d/%0d/%0d",
                             got.outcome, got.extra_hit, got.hits, got.misses, got.evictions);
                return;
            end
            want = expected_results.pop_front();
            checked++;
            if (got.outcome !== want.outcome || got.extra_hit !== want.extra_hit
                || got.hits !== want.hits || got.misses !== want.misses
                || got.evictions !== want.evictions)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                begin
                    $display("Mismatch on result %0d:", checked);
                    $display("  expected outcome %0d extra %0d hits %0d misses %0d evictions %0d",
                             want.outcome, want.extra_hit, want.hits, want.misses,
                             want.evictions);
                    $display("  actual   outcome %0d extra %0d hits %0d misses %0d evictions %0d",
                             got.outcome, got.extra_hit, got.hits, got.misses, got.evictions);
                end
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [OP_W-1:0]       operation = OP_LOAD;
    logic [ADDR_W-1:0]     address = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [OUTCOME_W-1:0]  outcome;
    logic                  extra_hit;
    logic [CNT_W-1:0]      hit_total;
    logic [CNT_W-1:0]      miss_total;
    logic [CNT_W-1:0]      eviction_total;

    cache_scoreboard board = new();

    bit steady = 1'b0;
    bit hold_done = 1'b0;
    int inputs_seen = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int items_sent = 0;
    int settings = 0;

    set_assoc_lru_cache_model_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .address        (address),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .outcome        (outcome),
        .extra_hit      (extra_hit),
        .hit_total      (hit_total),
        .miss_total     (miss_total),
        .eviction_total (eviction_total)
    );

    always #1 clk = ~clk;

    // Offer one item, after a random gap unless in a steady phase, and wait until the block takes it.
    task automatic send_item(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        address   <= addr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_input(op, addr);
        items_sent++;
    endtask

    // Mostly accesses that revisit a few sets with a few tags, some noise.
    task automatic send_random();
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] tag;
        logic [ADDR_W-1:0] set_idx;
        logic [ADDR_W-1:0] offs;
        int                sbits;
        int                obits;
        int                nways;
        if ($urandom_range(0, 99) < 15)
        begin
            op   = OP_W'($urandom_range(0, 3));
            addr = {$urandom, $urandom};
        end
        else
        begin
            op    = OP_W'($urandom_range(0, 2));
            sbits = board.eff_set_bits();
            obits = board.eff_offset_bits();
            nways = board.eff_ways();
            if ($urandom_range(0, 4) == 0)
                tag = {$urandom, $urandom};
            else
                tag = ADDR_W'($urandom_range(0, nways + 1));
            if ($urandom_range(0, 7) == 0)
                set_idx = {$urandom, $urandom};
            else
                set_idx = ADDR_W'($urandom_range(0, 3));
            set_idx = set_idx & ((64'd1 << sbits) - 64'd1);
            offs    = {$urandom, $urandom} & ((64'd1 << obits) - 64'd1);
            addr    = (tag << (sbits + obits)) | (set_idx << obits) | offs;
        end
        send_item(op, addr);
    endtask

    // Stop offering and wait until the block has returned everything.
    task automatic settle();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.write_reg(idx, data);
    endtask

    task automatic set_geometry(logic [CFG_DATA_W-1:0] sbits, logic [CFG_DATA_W-1:0] nways,
                                logic [CFG_DATA_W-1:0] obits, bit poke_spare);
        settle();
        write_reg(CFG_SET_BITS, sbits);
        write_reg(CFG_WAYS_IN_USE, nways);
        write_reg(CFG_OFFSET_BITS, obits);
        if (poke_spare)
            write_reg(CFG_SPARE, 5'h1f);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // Result side: check each taken item, then draw the next stall.
    always @(posedge clk)
    begin : receiver
        access_result_t got;
        int             wait_n;
        if (out_valid && !out_stall)
        begin
            got.outcome   = outcome;
            got.extra_hit = extra_hit;
            got.hits      = hit_total;
            got.misses    = miss_total;
            got.evictions = eviction_total;
            board.check_result(got);
        end
        if (in_valid && !in_stall)
            inputs_seen++;
        if (!hold_done && inputs_seen >= HOLD_AT)
        begin
            // One long hold-off so the block backs up into its input.
            hold_done  = 1'b1;
            stall_left = HOLD_LEN;
            out_stall <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (out_valid && !out_stall)
        begin
            wait_n     = steady ? 0 : $urandom_range(0, 19);
            stall_left = (wait_n != 0) ? wait_n - 1 : 0;
            out_stall <= (wait_n != 0);
        end
        else
            out_stall <= 1'b0;
    end

    // Ends the run when no channel has moved an item for too long.
    always @(posedge clk)
    begin : watchdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
                     quiet_cycles, board.pending());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin : main
        logic [CFG_DATA_W-1:0] prev_sbits;
        logic [CFG_DATA_W-1:0] prev_obits;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset geometry: one way, so every new tag in an occupied set evicts.
        send_item(OP_LOAD, 64'h0);
        send_item(OP_LOAD, 64'h0);
        send_item(OP_STORE, 64'h8);
        send_item(OP_LOAD, 64'h100);
        send_item(OP_MODIFY, 64'h200);
        send_item(OP_MODIFY, 64'h200);
        send_item(OP_UNKNOWN, 64'h0);
        send_item(OP_LOAD, '1);
        send_item(OP_STORE, '1);
        send_item(OP_LOAD, 64'h0);

        // Grow to two ways, shrink to one and regrow: the hidden way must keep its line.
        set_geometry(5'd4, 5'd2, 5'd4, 1'b0);
        send_item(OP_LOAD, 64'h100);
        send_item(OP_LOAD, 64'h0);
        set_geometry(5'd4, 5'd1, 5'd4, 1'b0);
        send_item(OP_LOAD, 64'h300);
        send_item(OP_MODIFY, 64'h300);
        set_geometry(5'd4, 5'd2, 5'd4, 1'b0);
        send_item(OP_LOAD, 64'h100);
        send_item(OP_STORE, 64'h300);

        // Random phases, the first ones at the register extremes.
        prev_sbits = 5'd4;
        prev_obits = 5'd4;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: set_geometry(5'd1, 5'd1, 5'd1, 1'b0);
                1: set_geometry(CFG_DATA_W'(DEF_MAX_SET_BITS), CFG_DATA_W'(DEF_MAX_WAYS),
                                CFG_DATA_W'(MAX_OFFSET), 1'b0);
                2: set_geometry(5'd0, 5'd0, 5'd0, 1'b1);
                3: set_geometry(5'd31, 5'd31, 5'd31, 1'b0);
                default:
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        prev_sbits = CFG_DATA_W'($urandom_range(1, DEF_MAX_SET_BITS));
                        prev_obits = CFG_DATA_W'($urandom_range(1, MAX_OFFSET));
                    end
                    set_geometry(prev_sbits, CFG_DATA_W'($urandom_range(1, DEF_MAX_WAYS)),
                                 prev_obits, 1'b0);
                end
            endcase
            steady = (p % 4 == 3);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_random();
        end
        steady = 1'b0;
        settle();

        $display("Ran %0d items over %0d register settings, %0d results checked.",
                 items_sent, settings, board.checked);
        $display("Predicted %0d hits, %0d misses, %0d evictions, %0d modify second hits.",
                 board.seen_hits, board.seen_misses, board.seen_evicts, board.seen_extra);
        if (board.errors == 0)
            $display("Simulation PASSED");
        else
        begin
            $display("%0d result errors", board.errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
